[sv/dtb_pkg.sv]
// Package for the deadline timer bank: command codes, widths and constants.
package dtb_pkg;

    // Bank size default and field widths.
    localparam int NUM_TIMERS_DEF = 16;
    localparam int IDX_FIELD_W    = 5;
    localparam int DUR_W          = 31;
    localparam int TIME_W         = 32;
    localparam int REM_W          = 31;
    localparam int CFG_W          = 16;

    // Stream packing widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 32;

    localparam logic [TIME_W-1:0] MS_PER_S      = 32'd1000;
    localparam logic [CFG_W-1:0]  MIN_CYC_RESET = 16'd1;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_START      = 3'd1,
        CMD_START_IDLE = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_POLL       = 3'd4,
        CMD_INFO       = 3'd5,
        CMD_RUNNING    = 3'd6,
        CMD_CYCLIC     = 3'd7
    } t_cmd;

endpackage

[sv/deadline_timer_bank.sv]
// Top level of the deadline timer bank: command pipeline, counter and deadline registers.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: timer_index, duration; tuser: command, unit
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: answer, remaining_ms
// cfg       in   i_cfg_wr_en                   i_cfg_wr_data: min_cyclic_seconds
//
// One transaction can be accepted in every cycle while the output is not stalled.
// A command is registered in the second stage, and its result in the output register:
// the input stage computes the timer length, the second stage the read-modify-write.
// Reset clears the millisecond counter, all deadlines (stopped) and sets the minimum
// cyclic period to one second. A stalled output holds its result; the input stage still
// takes one more transaction while the output waits, then stalls until the result is taken.
module deadline_timer_bank #(
    parameter int NUM_TIMERS = dtb_pkg::NUM_TIMERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [4:0] timer_index, [35:5] duration, [39:36] zero
    input  logic [dtb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] command, [3] unit_seconds
    input  logic [dtb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // Output stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] answer, [31:1] remaining_ms
    output logic [dtb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // Configuration write port for min_cyclic_seconds.
    input  logic                           i_cfg_wr_en,
    input  logic [dtb_pkg::CFG_W-1:0]      i_cfg_wr_data
);
    import dtb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Configuration register.
    logic [CFG_W-1:0] r_min_cyc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cyc <= MIN_CYC_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_cyc <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: unpack the transaction and work out the timer length.
    // ------------------------------------------------------------------
    t_cmd                   in_cmd;
    logic [IDX_FIELD_W-1:0] in_idx;
    logic [DUR_W-1:0]       in_dur;
    logic                   in_secs;
    logic [CFG_W-1:0]       cyc_raw;
    logic [CFG_W-1:0]       cyc_sec;
    logic [DUR_W-1:0]       mul_src;
    logic [TIME_W-1:0]      mul_ms;
    logic [TIME_W-1:0]      n_len;
    logic                   in_fire;

    assign in_cmd  = t_cmd'(s_axis_tuser[2:0]);
    assign in_secs = s_axis_tuser[3];
    assign in_idx  = s_axis_tdata[IDX_FIELD_W-1:0];
    assign in_dur  = s_axis_tdata[IDX_FIELD_W +: DUR_W];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Cyclic start looks at the low 16 bits only, as seconds, and is raised to the minimum.
    assign cyc_raw = in_dur[CFG_W-1:0];
    assign cyc_sec = (cyc_raw < r_min_cyc) ? r_min_cyc : cyc_raw;

    // One shared multiply by 1000 serves both seconds mode and cyclic start; the
    // product wraps to 32 bits just as the deadline arithmetic does.
    assign mul_src = (in_cmd == CMD_CYCLIC) ? DUR_W'(cyc_sec) : in_dur;
    assign mul_ms  = TIME_W'(mul_src) * MS_PER_S;
    assign n_len   = (in_cmd == CMD_CYCLIC || in_secs) ? mul_ms : TIME_W'(in_dur);

    logic                   r_s1_valid;
    t_cmd                   r_s1_cmd;
    logic [IDX_FIELD_W-1:0] r_s1_idx;
    logic [TIME_W-1:0]      r_s1_len;
    logic                   r_s1_cyc_ok;

    // ------------------------------------------------------------------
    // Handshake: the output register frees the second stage, which frees the input.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic out_free;
    logic s1_fire;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd    <= in_cmd;
            r_s1_idx    <= in_idx;
            r_s1_len    <= n_len;
            r_s1_cyc_ok <= (cyc_raw != '0);
        end
    end

    // ------------------------------------------------------------------
    // Second stage: read one deadline, compare against the counter, write back.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_deadlines [NUM_TIMERS];

    logic              idx_ok;
    logic [IDX_W-1:0]  dl_addr;
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] armed_sum;
    logic [TIME_W-1:0] armed;
    logic              running;

    logic              n_wr_en;
    logic [TIME_W-1:0] n_wr_data;
    logic              n_tick;
    logic              n_answer;
    logic [REM_W-1:0]  n_remain;

    assign idx_ok    = ({1'b0, r_s1_idx} < (IDX_FIELD_W + 1)'(NUM_TIMERS));
    assign dl_addr   = r_s1_idx[IDX_W-1:0];
    assign dl        = idx_ok ? r_deadlines[dl_addr] : '0;
    assign delta     = dl - r_now;
    assign running   = (dl != '0);
    assign armed_sum = r_now + r_s1_len;
    // Zero marks a stopped timer, so a deadline landing on zero is nudged to one.
    assign armed     = (armed_sum == '0) ? TIME_W'(1) : armed_sum;

    always_comb begin
        n_wr_en   = 1'b0;
        n_wr_data = armed;
        n_tick    = 1'b0;
        n_answer  = 1'b0;
        n_remain  = '0;
        unique case (r_s1_cmd)
            CMD_TICK: begin
                n_tick = 1'b1;
            end
            CMD_START: begin
                n_wr_en  = idx_ok;
                n_answer = idx_ok;
            end
            CMD_START_IDLE: begin
                n_wr_en  = idx_ok && !running;
                n_answer = idx_ok && !running;
            end
            CMD_STOP: begin
                n_wr_en   = idx_ok;
                n_wr_data = '0;
            end
            CMD_POLL: begin
                // Expired when the deadline is now or lies in the past half of the range.
                if (running && (delta == '0 || delta[TIME_W-1])) begin
                    n_wr_en   = 1'b1;
                    n_wr_data = '0;
                    n_answer  = 1'b1;
                end
            end
            CMD_INFO: begin
                if (running && !delta[TIME_W-1]) begin
                    n_answer = 1'b1;
                    n_remain = delta[REM_W-1:0];
                end
            end
            CMD_RUNNING: begin
                n_answer = running;
            end
            CMD_CYCLIC: begin
                n_wr_en  = idx_ok && r_s1_cyc_ok;
                n_answer = idx_ok && r_s1_cyc_ok;
            end
            default: begin
                n_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_deadlines[i] <= '0;
            end
        end else if (s1_fire) begin
            if (n_tick) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (n_wr_en) begin
                r_deadlines[dl_addr] <= n_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic             r_out_answer;
    logic [REM_W-1:0] r_out_remain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_answer <= n_answer;
            r_out_remain <= n_remain;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_remain, r_out_answer};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_cmd == CMD_TICK) |=> (r_now == $past(r_now) + TIME_W'(1)))
        else $error("counter did not advance on a tick");

    a_now_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_fire && r_s1_cmd == CMD_TICK) |=> $stable(r_now))
        else $error("counter moved without a tick");

    a_remain_needs_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[REM_W:1] != '0) |-> m_axis_tdata[0])
        else $error("remaining time given without a valid answer");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> s_axis_tready)
        else $error("input stalled while the pipeline stage is empty");

endmodule
